FILE: sv/permutation_unranker_assert.svh
// Assertion macros shared by the permutation unranker RTL.
// Expects clk and rst_n (active low) in the scope of each use.
`ifndef PERMUTATION_UNRANKER_ASSERT_SVH
`define PERMUTATION_UNRANKER_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define PU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define PU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/pu_pkg.sv
// Shared widths, factorial table and controller/datapath interface types
// for the permutation unranker. No dependencies.
package pu_pkg;

  localparam int MAX_ELEMENTS = 16;
  localparam int RANK_W       = 45;
  localparam int CNT_W        = 5;
  localparam int POS_W        = 4;
  localparam int ELEM_W       = 4;
  localparam int Q_W          = 4;  // quotient digit width per position
  localparam int STEP_W       = 2;  // index of a quotient bit

  // m! for m = 0 .. MAX_ELEMENTS
  localparam logic [RANK_W-1:0] FACT_TBL [0:MAX_ELEMENTS] = '{
    45'd1, 45'd1, 45'd2, 45'd6, 45'd24, 45'd120, 45'd720, 45'd5040,
    45'd40320, 45'd362880, 45'd3628800, 45'd39916800, 45'd479001600,
    45'd6227020800, 45'd87178291200, 45'd1307674368000,
    45'd20922789888000
  };

  // Commands from controller to datapath
  typedef struct packed {
    logic              load;      // take the input rank, reset element list
    logic              setup;     // fetch divisor for the current position
    logic              div_step;  // one restoring division step
    logic [STEP_W-1:0] step;      // quotient bit handled by div_step
    logic              emit;      // load output beat for current position
    logic              emit_err;  // load the error beat
  } pu_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic rank_bad;  // rank not below n!
    logic last_pos;  // current position is n-1
    logic out_free;  // output register can take a beat this cycle
  } pu_stat_t;

endpackage

FILE: sv/pu_ctrl.sv
// Sequencing FSM for the permutation unranker.
// Depends on pu_pkg for the command and status structs.
module pu_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  pu_pkg::pu_stat_t stat,
  output pu_pkg::pu_cmd_t  cmd
);
  import pu_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SETUP,
    S_DIV,
    S_EMIT,
    S_ERR
  } state_t;

  state_t            state_r;
  logic [STEP_W-1:0] step_r;

  assign in_ready = (state_r == S_IDLE);

  // Command decode
  always_comb begin
    cmd          = '0;
    cmd.step     = step_r;
    cmd.load     = in_valid && (state_r == S_IDLE);
    cmd.setup    = (state_r == S_SETUP);
    cmd.div_step = (state_r == S_DIV);
    cmd.emit     = (state_r == S_EMIT) && stat.out_free;
    cmd.emit_err = (state_r == S_ERR) && stat.out_free;
  end

  // State and step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) state_r <= S_CHECK;
        end
        S_CHECK: begin
          state_r <= stat.rank_bad ? S_ERR : S_SETUP;
        end
        S_SETUP: begin
          step_r  <= STEP_W'(Q_W - 1);
          state_r <= S_DIV;
        end
        S_DIV: begin
          step_r <= step_r - 1'b1;
          if (step_r == '0) state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (stat.out_free) state_r <= stat.last_pos ? S_IDLE : S_SETUP;
        end
        S_ERR: begin
          if (stat.out_free) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: sv/pu_datapath.sv
// Datapath of the permutation unranker: config register, rank remainder,
// restoring divider by factorials, ordered list of unused elements, output.
// Depends on pu_pkg.
module pu_datapath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [pu_pkg::CNT_W-1:0]   cfg_wdata,
  input  logic [pu_pkg::RANK_W-1:0]  in_rank,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic [pu_pkg::POS_W-1:0]   out_position,
  output logic [pu_pkg::ELEM_W-1:0]  out_element,
  output logic                       out_last,
  output logic                       out_rank_error,
  input  pu_pkg::pu_cmd_t            cmd,
  output pu_pkg::pu_stat_t           stat
);
  import pu_pkg::*;

  logic [CNT_W-1:0]       cfg_r;
  logic [CNT_W-1:0]       n_eff;
  logic [RANK_W-1:0]      rem_r;
  logic [RANK_W-1:0]      rem_nxt;
  logic [RANK_W-1:0]      fp_r;
  logic [Q_W-1:0]         q_r;
  logic [POS_W-1:0]       pos_r;
  logic [ELEM_W-1:0]      elem_r   [MAX_ELEMENTS];
  logic [ELEM_W-1:0]      elem_nxt [MAX_ELEMENTS];
  logic [CNT_W-1:0]       fact_idx;
  logic [RANK_W+Q_W-1:0]  trial;
  logic                   fits;
  logic                   out_valid_r;
  logic [POS_W-1:0]       out_position_r;
  logic [ELEM_W-1:0]      out_element_r;
  logic                   out_last_r;
  logic                   out_err_r;

  // Clamp element count into 1..MAX_ELEMENTS
  always_comb begin
    if (cfg_r == '0) n_eff = CNT_W'(1);
    else if (cfg_r > CNT_W'(MAX_ELEMENTS)) n_eff = CNT_W'(MAX_ELEMENTS);
    else n_eff = cfg_r;
  end

  // Status
  assign stat.rank_bad = (rem_r >= FACT_TBL[n_eff]);
  assign stat.last_pos = ({1'b0, pos_r} == (n_eff - CNT_W'(1)));
  assign stat.out_free = !out_valid_r || out_ready;

  // Divisor index (n-1-pos)!
  assign fact_idx = n_eff - CNT_W'(1) - {1'b0, pos_r};

  // Restoring division step: compare against divisor shifted by the bit
  assign trial   = {{Q_W{1'b0}}, fp_r} << cmd.step;
  assign fits    = ({{Q_W{1'b0}}, rem_r} >= trial);
  assign rem_nxt = rem_r - trial[RANK_W-1:0];

  // Remove the picked entry: entries above it slide down by one
  always_comb begin
    for (int i = 0; i < MAX_ELEMENTS - 1; i++) begin
      if (POS_W'(i) >= q_r) elem_nxt[i] = elem_r[i+1];
      else elem_nxt[i] = elem_r[i];
    end
    elem_nxt[MAX_ELEMENTS-1] = elem_r[MAX_ELEMENTS-1];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= CNT_W'(MAX_ELEMENTS);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) cfg_r <= cfg_wdata;
      if (cmd.emit || cmd.emit_err) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem_r <= in_rank;
      pos_r <= '0;
      for (int i = 0; i < MAX_ELEMENTS; i++) elem_r[i] <= ELEM_W'(i);
    end
    if (cmd.setup) begin
      fp_r <= FACT_TBL[fact_idx];
      q_r  <= '0;
    end
    if (cmd.div_step && fits) begin
      rem_r         <= rem_nxt;
      q_r[cmd.step] <= 1'b1;
    end
    if (cmd.emit) begin
      pos_r <= pos_r + 1'b1;
      for (int i = 0; i < MAX_ELEMENTS; i++) elem_r[i] <= elem_nxt[i];
    end
  end

  // Output beat register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_position_r <= pos_r;
      out_element_r  <= elem_r[q_r];
      out_last_r     <= stat.last_pos;
      out_err_r      <= 1'b0;
    end else if (cmd.emit_err) begin
      out_position_r <= '0;
      out_element_r  <= '0;
      out_last_r     <= 1'b1;
      out_err_r      <= 1'b1;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_position   = out_position_r;
  assign out_element    = out_element_r;
  assign out_last       = out_last_r;
  assign out_rank_error = out_err_r;

endmodule

FILE: sv/permutation_unranker.sv
// Top level of the permutation unranker: controller plus datapath.
// Depends on pu_pkg, pu_ctrl, pu_datapath and permutation_unranker_assert.svh.
//
// Usage: cfg_we/cfg_wdata set the element count n (reset 16; 0 acts as 1,
// values above 16 act as 16). Write it only while the block is idle.
// Input: one beat on in_valid/in_ready carries a rank. Output: one beat per
// position, 0 to n-1, with the element placed there; out_last marks the
// final beat. A rank of n! or more gives one beat with out_rank_error and
// out_last set, position and element zero.
// Timing: one rank at a time. After the accept, a check state compares the rank
// against n!, then each position runs divisor fetch, four restoring
// division steps of the 4-bit quotient and beat load, in that order.
// in_ready rises with the load of the last beat (of the error beat on error).
// A beat still held by out_ready when the next one is due delays that load,
// and the rank, cycle for cycle.
// Reset (rst_n low, synchronous) returns to idle and empties the output.
module permutation_unranker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [pu_pkg::CNT_W-1:0]   cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [pu_pkg::RANK_W-1:0]  in_rank,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [pu_pkg::POS_W-1:0]   out_position,
  output logic [pu_pkg::ELEM_W-1:0]  out_element,
  output logic                       out_last,
  output logic                       out_rank_error
);
  import pu_pkg::*;

  pu_cmd_t  cmd;
  pu_stat_t stat;

  pu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pu_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_rank        (in_rank),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_position   (out_position),
    .out_element    (out_element),
    .out_last       (out_last),
    .out_rank_error (out_rank_error),
    .cmd            (cmd),
    .stat           (stat)
  );

  // Checks
`include "permutation_unranker_assert.svh"

  `PU_ASSERT_NOW(a_err_is_last, out_valid && out_rank_error, out_last, "error beat not last")
  `PU_ASSERT_NEXT(a_one_rank, in_valid && in_ready, !in_ready, "second rank taken while busy")
  `PU_ASSERT_NOW(a_emit_free, cmd.emit || cmd.emit_err, stat.out_free, "beat loaded over held beat")
  `PU_ASSERT_NEXT(a_last_idle, cmd.emit && stat.last_pos, in_ready && out_last, "no idle after last")

endmodule

FILE: verif/pu_checker.sv
// Scoreboard for the permutation unranker: watches the config, input and result channels,
// predicts the beats of each rank, and compares them with what the block sends.
// Depends on pu_pkg for the port widths.
module pu_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [pu_pkg::CNT_W-1:0]   cfg_wdata,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [pu_pkg::RANK_W-1:0]  in_rank,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [pu_pkg::POS_W-1:0]   out_position,
  input  logic [pu_pkg::ELEM_W-1:0]  out_element,
  input  logic                       out_last,
  input  logic                       out_rank_error,
  output int unsigned                errors,
  output int unsigned                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [pu_pkg::POS_W-1:0]  position;
    logic [pu_pkg::ELEM_W-1:0] element;
    logic                      last;
    logic                      rank_error;
  } perm_beat_t;

  perm_beat_t                 perm_beats_q[$];
  logic [pu_pkg::CNT_W-1:0]   count_reg;

  function automatic logic [63:0] fact(input int m);
    logic [63:0] f;
    f = 1;
    for (int i = 2; i <= m; i++) f = f * i;
    return f;
  endfunction

  // Expand one rank into its beats, in position order
  function automatic void unrank_to_beats(input logic [pu_pkg::RANK_W-1:0] rank,
                                          input logic [pu_pkg::CNT_W-1:0] raw_count);
    int          n;
    int          seen;
    int          pick;
    logic [63:0] rem;
    logic [63:0] digit;
    logic [63:0] radix;
    logic [15:0] taken;
    perm_beat_t  b;
    n = raw_count;
    if (n < 1) n = 1;
    if (n > pu_pkg::MAX_ELEMENTS) n = pu_pkg::MAX_ELEMENTS;
    // out-of-range rank: one flagged beat
    if (64'(rank) >= fact(n)) begin
      b = '{position: '0, element: '0, last: 1'b1, rank_error: 1'b1};
      perm_beats_q = {perm_beats_q, b};
      return;
    end
    rem   = 64'(rank);
    taken = '0;
    for (int p = 0; p < n; p++) begin
      radix = fact(n - 1 - p);
      digit = rem / radix;
      rem   = rem % radix;
      seen  = 0;
      pick  = 0;
      // digit-th free element in ascending order
      for (int v = 0; v < n; v++) begin
        if (!taken[v]) begin
          if (seen == digit) begin
            pick = v;
            break;
          end
          seen++;
        end
      end
      taken[pick] = 1'b1;
      b.position   = p[pu_pkg::POS_W-1:0];
      b.element    = pick[pu_pkg::ELEM_W-1:0];
      b.last       = (p == n - 1);
      b.rank_error = 1'b0;
      perm_beats_q = {perm_beats_q, b};
    end
  endfunction

  // Track config, compare result beats, then queue new predictions
  always @(posedge clk) begin
    perm_beat_t want;
    if (!rst_n) begin
      count_reg = 5'd16;
      perm_beats_q.delete();
    end else begin
      if (cfg_we) count_reg = cfg_wdata;
      if (out_valid && out_ready) begin
        if (perm_beats_q.size() == 0) begin
          $error("unexpected result beat: position %0d element %0d", out_position, out_element);
          errors++;
        end else begin
          want = perm_beats_q.pop_front();
          if (out_position !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, out_position);
            errors++;
          end
          if (out_element !== want.element) begin
            $error("element: expected %0d, got %0d", want.element, out_element);
            errors++;
          end
          if (out_last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_last);
            errors++;
          end
          if (out_rank_error !== want.rank_error) begin
            $error("rank_error: expected %0d, got %0d", want.rank_error, out_rank_error);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) unrank_to_beats(in_rank, count_reg);
    end
    pending <= perm_beats_q.size();
  end

endmodule

FILE: verif/tb_top.sv
// Testbench top for the permutation unranker: clock, reset, rank stimulus, element
// count settings and the verdict. Depends on pu_pkg, permutation_unranker and pu_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 1000000;

  logic                       clk            = 1'b0;
  logic                       rst_n          = 1'b0;
  logic                       cfg_we         = 1'b0;
  logic [pu_pkg::CNT_W-1:0]   cfg_wdata      = '0;
  logic                       in_valid       = 1'b0;
  logic                       in_ready;
  logic [pu_pkg::RANK_W-1:0]  in_rank        = '0;
  logic                       out_valid;
  logic                       out_ready      = 1'b0;
  logic [pu_pkg::POS_W-1:0]   out_position;
  logic [pu_pkg::ELEM_W-1:0]  out_element;
  logic                       out_last;
  logic                       out_rank_error;

  int unsigned errors;
  int unsigned pending;
  int unsigned cycles = 0;
  logic        steady = 1'b0;  // no idling on either side while set
  int          cur_n  = 16;    // element count in effect

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  permutation_unranker dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_rank        (in_rank),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_position   (out_position),
    .out_element    (out_element),
    .out_last       (out_last),
    .out_rank_error (out_rank_error)
  );

  pu_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_rank        (in_rank),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_position   (out_position),
    .out_element    (out_element),
    .out_last       (out_last),
    .out_rank_error (out_rank_error),
    .errors         (errors),
    .pending        (pending)
  );

  // Result side stalls about 36 percent of the time, never while steady is set
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 36);
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Offer one rank, hold it until accepted, then maybe idle
  task automatic send_rank(input logic [pu_pkg::RANK_W-1:0] r);
    int gap;
    in_valid <= 1'b1;
    in_rank  <= r;
    do @(posedge clk); while (!in_ready);
    gap = 0;
    if (!steady && $urandom_range(0, 99) < 36)
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 110) : $urandom_range(1, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold off the sender until every predicted beat has been seen
  task automatic drain;
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    while (!in_ready) @(posedge clk);
  endtask

  // Element count write; block is idle here
  task automatic write_count(input logic [pu_pkg::CNT_W-1:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_n = (v == 0) ? 1 : (v > pu_pkg::MAX_ELEMENTS) ? pu_pkg::MAX_ELEMENTS : int'(v);
  endtask

  function automatic logic [63:0] nfact(input int m);
    logic [63:0] f;
    f = 1;
    for (int i = 2; i <= m; i++) f = f * i;
    return f;
  endfunction

  // Mostly legal ranks, with boundaries, overflow and raw noise mixed in
  function automatic logic [pu_pkg::RANK_W-1:0] pick_rank(input int n);
    logic [63:0] f;
    logic [63:0] r;
    logic [63:0] span;
    int          sel;
    f    = nfact(n);
    r    = {$urandom, $urandom};
    span = (64'd1 << pu_pkg::RANK_W) - f;
    sel  = $urandom_range(0, 99);
    if (sel < 74)      return pu_pkg::RANK_W'(r % f);
    else if (sel < 80) return pu_pkg::RANK_W'(f - 1);
    else if (sel < 84) return pu_pkg::RANK_W'(f);
    else if (sel < 92) return pu_pkg::RANK_W'(f + r % span);
    else               return r[pu_pkg::RANK_W-1:0];
  endfunction

  localparam logic [pu_pkg::CNT_W-1:0] PHASE_COUNTS [0:10] =
    '{5'd3, 5'd16, 5'd5, 5'd1, 5'd8, 5'd24, 5'd12, 5'd2, 5'd0, 5'd13, 5'd16};

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset count of 16, extremes and overflow
    send_rank('0);
    send_rank(45'd1);
    send_rank(pu_pkg::RANK_W'(nfact(16) - 1));
    send_rank(pu_pkg::RANK_W'(nfact(16)));
    send_rank('1);
    send_rank(45'h0AAA_AAAA_AAAA);
    send_rank(45'h1555_5555_5555);
    send_rank(45'h1000_0000_0000);
    // single element
    write_count(5'd1);
    send_rank('0);
    send_rank(45'd1);
    send_rank('1);
    // zero count acts as one
    write_count(5'd0);
    send_rank('0);
    send_rank(45'd1);
    write_count(5'd2);
    send_rank('0);
    send_rank(45'd1);
    send_rank(45'd2);
    // saturation above the maximum count
    write_count(5'd31);
    send_rank('0);
    send_rank(pu_pkg::RANK_W'(nfact(16) - 1));
    send_rank(pu_pkg::RANK_W'(nfact(16)));

    // Random phases, one element count each
    foreach (PHASE_COUNTS[ph]) begin
      write_count(PHASE_COUNTS[ph]);
      steady = (ph == 5);
      for (int i = 0; i < 30; i++) send_rank(pick_rank(cur_n));
      steady = 1'b0;
    end

    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
